FILE: rtl/core/assert_macros.svh
// assertion macros shared by the checker files
// no dependencies; clock i_clk and reset i_rst_n must exist where used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define CLSP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("clsp same-cycle check failed");

// next-cycle implication, disabled during reset
`define CLSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("clsp next-cycle check failed");

`endif

FILE: rtl/core/clsp_pkg.sv
// shared types, constants and helpers of the cone lane steering core
// no dependencies; imported by every module of the core
package clsp_pkg;

    localparam int KEPT_PER_COLOR = 3;
    localparam int CNT_W          = $clog2(KEPT_PER_COLOR + 1);

    // fixed-point constants
    localparam logic [12:0] ONE_COLOR_SHIFT = 13'd6400;
    localparam logic [26:0] DEG_TO_RAD_Q32  = 27'd74961321;
    localparam logic [14:0] INV_PI_Q16      = 15'd20861;
    localparam logic [13:0] STEER_LIMIT     = 14'd10863;
    localparam logic [6:0]  LOOKAHEAD_FULL  = 7'd100;
    localparam logic [20:0] BEZ_DIVISOR     = 21'd2000000;
    localparam logic [37:0] BEZ_BIAS        = 38'd1000000;
    localparam logic [20:0] WMID_DIVISOR    = 21'd24;
    localparam logic [37:0] WMID_BIAS       = 38'd12;
    // reciprocals, rounded down: 2^46 / 15625 on the numerator over 2^11, 2^32 / 24
    localparam logic [32:0] BEZ_RECIP       = 33'd4503599627;
    localparam logic [27:0] WMID_RECIP      = 28'd178956970;

    // configuration register indices
    typedef enum logic [2:0] {
        CFG_KP      = 3'd0,
        CFG_KI      = 3'd1,
        CFG_BASE    = 3'd2,
        CFG_OFFSET  = 3'd3,
        CFG_REC_L   = 3'd4,
        CFG_REC_R   = 3'd5,
        CFG_LOOK    = 3'd6,
        CFG_WIDTH   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0]        kp;
        logic [15:0]        ki;
        logic signed [15:0] base;
        logic signed [15:0] offset;
        logic signed [15:0] rec_l;
        logic signed [15:0] rec_r;
        logic [6:0]         look;
        logic [12:0]        width;
    } t_cfg;

    // one kept cone
    typedef struct packed {
        logic        valid;
        logic [15:0] y;
        logic [15:0] x;
    } t_entry;

    // what a cell hands to its neighbour
    typedef struct packed {
        logic   stay;
        t_entry ent;
    } t_link;

    // snapshot of the kept cones at frame end
    typedef struct packed {
        logic [CNT_W-1:0]                     nb;
        logic [CNT_W-1:0]                     ny;
        logic [KEPT_PER_COLOR-1:0][15:0]      bx;
        logic [KEPT_PER_COLOR-1:0][15:0]      yx;
    } t_frame;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic signed [15:0] steer;
        logic               found;
    } t_result;

    function automatic logic [CNT_W-1:0] count_valid(input logic [KEPT_PER_COLOR-1:0] v);
        logic [CNT_W-1:0] n;
        n = '0;
        for (int i = 0; i < KEPT_PER_COLOR; i++) begin
            n = n + CNT_W'(v[i]);
        end
        return n;
    endfunction

endpackage

FILE: rtl/core/cone_lane_steering_pi_core.sv
// cone lane steering core: chain of nearest-cone cells per colour and a
// frame-end pi sequencer; depends on clsp_pkg, clsp_cell, clsp_ctrl
//
// usage:
//   s_axis carries one cone centroid per transaction (tdata x then y, tuser
//   has_centroid then colour); tlast closes the frame.
//   each colour keeps its three nearest cones in a row of three cells that
//   shift towards the far end as a nearer cone is inserted.
//   a transaction without tlast is accepted whenever the sequencer is idle and gives no result.
//   a tlast transaction starts the sequencer; s_axis_tready is low until the
//   result enters the output register. with no cone the sequencer goes from
//   select to the handoff, with one or two colours through the pi steps, and
//   with three pairs through the reciprocal divide on the weighted midpoint or
//   on the bezier (select, 11 multiplier steps, reciprocal divide, 8 pi steps, handoff).
//   m_axis delivers one transaction per frame (left, right, steer; tuser
//   target_found) from an output register; while the receiver stalls the
//   register holds, further non-final centroids are still accepted and a
//   second frame end waits in the sequencer with s_axis_tready low.
//   configuration writes are always ready and take effect at once; write
//   them only while the core is idle.
//   reset (synchronous, active low) empties the lists, clears the integral
//   and loads the default register values.
module cone_lane_steering_pi_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // x_pos[15:0], y_pos[31:16]
    input  logic        s_axis_tlast,
    input  logic [1:0]  s_axis_tuser,   // has_centroid[0], cone_color[1]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // left_drive[15:0], right_drive[31:16], steer_angle[47:32]
    output logic [0:0]  m_axis_tuser,   // target_found[0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import clsp_pkg::*;

    t_cfg    r_cfg;
    logic    r_out_valid;
    t_result r_out;

    t_link   lnk [2][KEPT_PER_COLOR+1];
    t_entry  new_ent;
    logic    in_acc;
    logic    load [2];
    logic    res_ready;
    logic    res_valid;
    logic    busy;
    t_result res;
    t_frame  frame;
    logic [KEPT_PER_COLOR-1:0] bvalid, yvalid;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !busy;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign new_ent.valid = 1'b1;
    assign new_ent.x     = s_axis_tdata[15:0];
    assign new_ent.y     = s_axis_tdata[31:16];
    assign load[0]       = in_acc && s_axis_tuser[0] && !s_axis_tuser[1];
    assign load[1]       = in_acc && s_axis_tuser[0] && s_axis_tuser[1];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp     <= 16'd1966;
            r_cfg.ki     <= 16'd66;
            r_cfg.base   <= 16'sd1638;
            r_cfg.offset <= 16'sd1638;
            r_cfg.rec_l  <= 16'sd1638;
            r_cfg.rec_r  <= 16'sd2458;
            r_cfg.look   <= 7'd65;
            r_cfg.width  <= 13'd1280;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_KP:     r_cfg.kp     <= i_cfg_data;
                CFG_KI:     r_cfg.ki     <= i_cfg_data;
                CFG_BASE:   r_cfg.base   <= i_cfg_data;
                CFG_OFFSET: r_cfg.offset <= i_cfg_data;
                CFG_REC_L:  r_cfg.rec_l  <= i_cfg_data;
                CFG_REC_R:  r_cfg.rec_r  <= i_cfg_data;
                CFG_LOOK:   r_cfg.look   <= i_cfg_data[6:0];
                CFG_WIDTH:  r_cfg.width  <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // cell chains, nearest cone at the head
    for (genvar gc = 0; gc < 2; gc++) begin : g_color
        assign lnk[gc][0].stay = 1'b1;
        assign lnk[gc][0].ent  = '0;
        for (genvar gi = 0; gi < KEPT_PER_COLOR; gi++) begin : g_cell
            clsp_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_load  (load[gc]),
                .i_clear (res_valid && res_ready),
                .i_new   (new_ent),
                .i_prev  (lnk[gc][gi]),
                .o_link  (lnk[gc][gi+1])
            );
        end
    end

    // frame snapshot for the sequencer
    always_comb begin
        for (int i = 0; i < KEPT_PER_COLOR; i++) begin
            bvalid[i]   = lnk[0][i+1].ent.valid;
            yvalid[i]   = lnk[1][i+1].ent.valid;
            frame.bx[i] = lnk[0][i+1].ent.x;
            frame.yx[i] = lnk[1][i+1].ent.x;
        end
        frame.nb = count_valid(bvalid);
        frame.ny = count_valid(yvalid);
    end

    clsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (in_acc && s_axis_tlast),
        .i_cfg       (r_cfg),
        .i_frame     (frame),
        .o_busy      (busy),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // output register
    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out.steer, r_out.right, r_out.left};
    assign m_axis_tuser  = r_out.found;

endmodule

FILE: rtl/core/clsp_cell.sv
// one insertion cell of the nearest-cone chain
// depends on clsp_pkg
module clsp_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  logic           i_clear,
    input  clsp_pkg::t_entry i_new,
    input  clsp_pkg::t_link  i_prev,
    output clsp_pkg::t_link  o_link
);
    import clsp_pkg::*;

    logic        r_valid;
    logic [15:0] r_x;
    logic [15:0] r_y;
    logic        stay;

    // a held cone at least as near as the new one keeps its place
    assign stay = r_valid && (r_y >= i_new.y);

    assign o_link.stay      = stay;
    assign o_link.ent.valid = r_valid;
    assign o_link.ent.x     = r_x;
    assign o_link.ent.y     = r_y;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clear) begin
            r_valid <= 1'b0;
        end else if (i_load && !stay) begin
            r_valid <= i_prev.stay ? 1'b1 : i_prev.ent.valid;
        end
    end

    // payload: take the new cone here, or the neighbour's as it shifts down
    always_ff @(posedge i_clk) begin
        if (i_load && !stay) begin
            if (i_prev.stay) begin
                r_x <= i_new.x;
                r_y <= i_new.y;
            end else begin
                r_x <= i_prev.ent.x;
                r_y <= i_prev.ent.y;
            end
        end
    end

endmodule

FILE: rtl/core/clsp_ctrl.sv
// frame-end sequencer: target pick, reciprocal divide, pi step, drive mix
// depends on clsp_pkg; one shared signed multiplier, registered product
module clsp_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  clsp_pkg::t_cfg    i_cfg,
    input  clsp_pkg::t_frame  i_frame,
    output logic              o_busy,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output clsp_pkg::t_result o_res
);
    import clsp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SEL, S_BEZ, S_DIV, S_DIVM, S_DIVC, S_ERR, S_KP, S_KI, S_DEG,
        S_RADM, S_RAD, S_TERMM, S_TERM, S_OUT
    } t_state;

    t_state              r_state;
    logic [3:0]          r_step;
    logic [13:0]         r_uu;
    logic [13:0]         r_kk;
    logic [3:0][19:0]    r_c;
    logic [37:0]         r_acc;
    logic [37:0]         r_num;
    logic                r_wmid;
    logic [16:0]         r_q;
    logic signed [17:0]  r_target;
    logic signed [18:0]  r_err;
    logic signed [31:0]  r_integ;
    logic signed [35:0]  r_pterm;
    logic signed [27:0]  r_deg;
    logic signed [15:0]  r_rad;
    logic signed [61:0]  r_prod;
    t_result             r_res;

    logic signed [33:0]  mul_a;
    logic signed [27:0]  mul_b;
    logic [16:0]         p0, p1, p2, w16;
    logic [6:0]          u;
    logic [8:0]          k3, u3;
    logic [20:0]         wsum;
    logic [37:0]         div_in;
    logic [20:0]         div_dsr;
    logic [16:0]         div_q;
    logic [37:0]         div_rem;
    logic                div_ge;
    logic signed [18:0]  err_c;
    logic signed [32:0]  integ_sum;
    logic signed [31:0]  integ_sat;
    logic signed [61:0]  deg_sum;
    logic signed [27:0]  deg_c;
    logic                prod_neg;
    logic [61:0]         prod_mag;
    logic [23:0]         rad_mag;
    logic [13:0]         rad_lim;
    logic [12:0]         term_mag;
    logic signed [13:0]  term;
    logic signed [16:0]  common;
    logic signed [17:0]  left_w, right_w;
    logic signed [15:0]  left_s, right_s;

    // pair sums and bezier weights
    always_comb begin
        p0   = {1'b0, i_frame.bx[0]} + {1'b0, i_frame.yx[0]};
        p1   = {1'b0, i_frame.bx[1]} + {1'b0, i_frame.yx[1]};
        p2   = {1'b0, i_frame.bx[2]} + {1'b0, i_frame.yx[2]};
        w16  = {i_cfg.width, 4'b0};
        u    = LOOKAHEAD_FULL - i_cfg.look;
        k3   = 9'(i_cfg.look) * 9'd3;
        u3   = 9'(u) * 9'd3;
        wsum = 21'(p0) * 21'd7 + 21'(p1) * 21'd4 + 21'(p2);
    end

    // shared multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_BEZ: begin
                case (r_step)
                    4'd0: begin mul_a = 34'(u);        mul_b = 28'(u);          end
                    4'd1: begin mul_a = 34'(i_cfg.look); mul_b = 28'(i_cfg.look); end
                    4'd2: begin mul_a = 34'(r_uu);     mul_b = 28'(u);          end
                    4'd3: begin mul_a = 34'(r_uu);     mul_b = 28'(k3);         end
                    4'd4: begin mul_a = 34'(r_kk);     mul_b = 28'(u3);         end
                    4'd5: begin mul_a = 34'(r_kk);     mul_b = 28'(i_cfg.look); end
                    4'd6: begin mul_a = 34'(r_c[0]);   mul_b = 28'(w16);        end
                    4'd7: begin mul_a = 34'(r_c[1]);   mul_b = 28'(p0);         end
                    4'd8: begin mul_a = 34'(r_c[2]);   mul_b = 28'(p1);         end
                    default: begin mul_a = 34'(r_c[3]); mul_b = 28'(p2);       end
                endcase
            end
            S_DIV: begin
                mul_a = r_wmid ? 34'(WMID_RECIP) : 34'(BEZ_RECIP);
                mul_b = r_wmid ? 28'(r_num[20:0]) : 28'(r_num[37:11]);
            end
            S_DIVM:  begin mul_a = 34'(div_q);   mul_b = 28'(div_dsr);        end
            S_KP:    begin mul_a = 34'(r_err);   mul_b = 28'(i_cfg.kp);       end
            S_KI:    begin mul_a = 34'(r_integ); mul_b = 28'(i_cfg.ki);       end
            S_RADM:  begin mul_a = 34'(r_deg);   mul_b = 28'(DEG_TO_RAD_Q32); end
            S_TERMM: begin mul_a = 34'(r_rad);   mul_b = 28'(INV_PI_Q16);     end
            default: begin mul_a = '0;           mul_b = '0;                  end
        endcase
    end

    // divider numerator, quotient estimate from the reciprocal and its correction
    always_comb begin
        if (r_state == S_SEL) begin
            div_in = 38'(wsum) + WMID_BIAS;
        end else begin
            div_in = r_acc + r_prod[37:0] + BEZ_BIAS;
        end
        div_dsr = r_wmid ? WMID_DIVISOR : BEZ_DIVISOR;
        div_q   = r_wmid ? r_prod[48:32] : r_prod[58:42];
        div_rem = r_num - r_prod[37:0];
        div_ge  = div_rem >= 38'(div_dsr);
    end

    // error and saturating integral
    always_comb begin
        err_c     = 19'(r_target) - $signed({3'b0, i_cfg.width, 3'b0});
        integ_sum = 33'(r_integ) + 33'(err_c);
        if (integ_sum > 33'sh0_7FFF_FFFF) begin
            integ_sat = 32'sh7FFF_FFFF;
        end else if (integ_sum < -33'sh0_8000_0000) begin
            integ_sat = -32'sh8000_0000;
        end else begin
            integ_sat = integ_sum[31:0];
        end
    end

    // degree sum clamped to +-64 deg
    always_comb begin
        deg_sum = 62'(r_pterm) + r_prod;
        if (deg_sum > 62'sd67108864) begin
            deg_c = 28'sd67108864;
        end else if (deg_sum < -62'sd67108864) begin
            deg_c = -28'sd67108864;
        end else begin
            deg_c = deg_sum[27:0];
        end
    end

    // rounding of the product, half away from zero
    always_comb begin
        prod_neg = r_prod[61];
        prod_mag = prod_neg ? 62'(-r_prod) : 62'(r_prod);
        rad_mag  = 24'((prod_mag + (62'd1 << 37)) >> 38);
        rad_lim  = (rad_mag > 24'(STEER_LIMIT)) ? STEER_LIMIT : rad_mag[13:0];
        term_mag = 13'((prod_mag + (62'd1 << 15)) >> 16);
        term     = prod_neg ? -$signed({1'b0, term_mag}) : $signed({1'b0, term_mag});
        common   = 17'(i_cfg.base) + 17'(i_cfg.offset);
        left_w   = 18'(common) + 18'(term);
        right_w  = 18'(common) - 18'(term);
        left_s   = (left_w > 18'sd32767) ? 16'sh7FFF :
                   (left_w < -18'sd32768) ? -16'sh8000 : left_w[15:0];
        right_s  = (right_w > 18'sd32767) ? 16'sh7FFF :
                   (right_w < -18'sd32768) ? -16'sh8000 : right_w[15:0];
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_OUT);
    assign o_res       = r_res;

    // sequencer
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_integ <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_SEL;
                    end
                end
                S_SEL: begin
                    r_step <= '0;
                    if (i_frame.nb == '0 && i_frame.ny == '0) begin
                        r_integ     <= '0;
                        r_res.left  <= i_cfg.rec_l;
                        r_res.right <= i_cfg.rec_r;
                        r_res.steer <= '0;
                        r_res.found <= 1'b0;
                        r_state     <= S_OUT;
                    end else if (i_frame.nb == CNT_W'(KEPT_PER_COLOR) &&
                                 i_frame.ny == CNT_W'(KEPT_PER_COLOR)) begin
                        if (i_cfg.look < LOOKAHEAD_FULL) begin
                            r_state <= S_BEZ;
                        end else begin
                            r_num   <= div_in;
                            r_wmid  <= 1'b1;
                            r_state <= S_DIV;
                        end
                    end else if (i_frame.nb != '0 && i_frame.ny != '0) begin
                        r_target <= 18'((18'(p0) + 18'd1) >> 1);
                        r_state  <= S_ERR;
                    end else if (i_frame.ny != '0) begin
                        r_target <= 18'(i_frame.yx[0]) + 18'(ONE_COLOR_SHIFT);
                        r_state  <= S_ERR;
                    end else begin
                        r_target <= 18'(i_frame.bx[0]) - 18'(ONE_COLOR_SHIFT);
                        r_state  <= S_ERR;
                    end
                end
                S_BEZ: begin
                    r_step <= r_step + 4'd1;
                    case (r_step)
                        4'd0: ;
                        4'd1: r_uu <= r_prod[13:0];
                        4'd2: r_kk <= r_prod[13:0];
                        4'd3, 4'd4, 4'd5, 4'd6: r_c[2'(r_step - 4'd3)] <= r_prod[19:0];
                        4'd7: r_acc <= r_prod[37:0];
                        4'd8, 4'd9: r_acc <= r_acc + r_prod[37:0];
                        default: begin
                            r_num   <= div_in;
                            r_wmid  <= 1'b0;
                            r_state <= S_DIV;
                        end
                    endcase
                end
                // reciprocal product issued, estimate may be one low
                S_DIV: r_state <= S_DIVM;
                S_DIVM: begin
                    r_q     <= div_q;
                    r_state <= S_DIVC;
                end
                S_DIVC: begin
                    r_target <= 18'(r_q) + 18'(div_ge);
                    r_state  <= S_ERR;
                end
                S_ERR: begin
                    r_err   <= err_c;
                    r_integ <= integ_sat;
                    r_state <= S_KP;
                end
                S_KP:   r_state <= S_KI;
                S_KI: begin
                    r_pterm <= r_prod[35:0];
                    r_state <= S_DEG;
                end
                S_DEG: begin
                    r_deg   <= deg_c;
                    r_state <= S_RADM;
                end
                S_RADM: r_state <= S_RAD;
                S_RAD: begin
                    r_rad   <= prod_neg ? -$signed({2'b0, rad_lim}) : $signed({2'b0, rad_lim});
                    r_state <= S_TERMM;
                end
                S_TERMM: r_state <= S_TERM;
                S_TERM: begin
                    r_res.left  <= left_s;
                    r_res.right <= right_s;
                    r_res.steer <= r_rad;
                    r_res.found <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/core/clsp_checker.sv
// port-level checks for the cone lane steering core, bound to the top level
// depends on assert_macros.svh
`include "assert_macros.svh"

module clsp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    logic               out_stall;
    logic               in_last;
    logic signed [15:0] steer;

    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign in_last   = s_axis_tvalid && s_axis_tready && s_axis_tlast;
    assign steer     = m_axis_tdata[47:32];

    // a stalled result holds
    `CLSP_ASSERT_NEXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

    // frame end blocks the input while the step runs
    `CLSP_ASSERT_NEXT(a_frame_busy, in_last, !s_axis_tready)

    // recovery drive carries no steering
    `CLSP_ASSERT_NOW(a_recovery_steer, m_axis_tvalid && !m_axis_tuser[0], steer == 16'sd0)

    // steering stays inside the clamp
    `CLSP_ASSERT_NOW(a_steer_clamp, m_axis_tvalid, (steer <= 16'sd10863) && (steer >= -16'sd10863))

endmodule

bind cone_lane_steering_pi_core clsp_checker u_clsp_checker (.*);
